### hw/rtl/interval_buffer_reuse_matcher_top_macros.svh
// Assertion macros for the interval buffer reuse matcher.
`ifndef INTERVAL_BUFFER_REUSE_MATCHER_TOP_MACROS_SVH
`define INTERVAL_BUFFER_REUSE_MATCHER_TOP_MACROS_SVH
`ifndef SYNTH
`define IBRM_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define IBRM_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define IBRM_ASSERT_IMP(label, clk, rst_n, a, c)
`define IBRM_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

### hw/rtl/ibrm_pkg.sv
// Shared types for the interval buffer reuse matcher.
package ibrm_pkg;
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAND,
        ST_CHECK,
        ST_RUSR,
        ST_RCHECK,
        ST_DONE
    } state_t;
endpackage

### hw/rtl/interval_buffer_reuse_matcher_top.sv
// Top level of the interval buffer reuse matcher.
//
// Usage: drive restart, def_stmt, last_stmt, space_id and buffer_size
// and raise start while busy is low; the word is taken at that edge and busy
// rises. The block walks the stored table one entry at a time: for each
// earlier candidate it reads the entry, and if the candidate passes the space,
// size and overlap tests it walks the stored entries looking for a reuser of
// that candidate that clashes, taking the candidate if none does. The cost is
// set by the single read port of the entry memory. The result appears for
// exactly one cycle with done high; busy stays high through that cycle and
// drops in the cycle after. The receiver cannot stall. A full table gives
// table_full with no walk. Reset clears the entry count and state; the table
// memory itself is not cleared, since only entries below the count are ever
// used. Restart resets the count before the item.
module interval_buffer_reuse_matcher_top #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        restart,
    input  logic [15:0] def_stmt,
    input  logic [15:0] last_stmt,
    input  logic [2:0]  space_id,
    input  logic [31:0] buffer_size,
    output logic        done,
    output logic [7:0]  entry_index,
    output logic        reuse_found,
    output logic [7:0]  source_index,
    output logic        table_full
);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    // entry word: def, last, space, size, link valid, link index
    localparam int EW = 16 + 16 + 3 + 32 + 1 + AW;

    logic [EW-1:0] mem [MAX_ENTRIES];
    logic [EW-1:0] rd_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[mem_raddr];
    end

    ibrm_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cand_reg, cand_next;
    logic [CW-1:0] k_reg, k_next;
    logic [15:0]   d_reg, l_reg;
    logic [2:0]    sp_reg;
    logic [31:0]   sz_reg;
    logic          found_reg, found_next;
    logic          full_reg, full_next;

    logic [15:0]   r_d, r_l;
    logic [2:0]    r_sp;
    logic [31:0]   r_sz;
    logic          r_lv;
    logic [AW-1:0] r_li;
    assign {r_d, r_l, r_sp, r_sz, r_lv, r_li} = rd_reg;

    logic r_ovl;
    assign r_ovl = !((r_l < d_reg) || (l_reg < r_d));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ibrm_pkg::ST_IDLE;
            count_reg <= '0;
            cand_reg  <= '0;
            k_reg     <= '0;
            found_reg <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cand_reg  <= cand_next;
            k_reg     <= k_next;
            found_reg <= found_next;
            full_reg  <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            d_reg  <= def_stmt;
            l_reg  <= last_stmt;
            sp_reg <= space_id;
            sz_reg <= buffer_size;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cand_next  = cand_reg;
        k_next     = k_reg;
        found_next = found_reg;
        full_next  = full_reg;
        mem_we     = 1'b0;
        mem_waddr  = count_reg[AW-1:0];
        mem_wdata  = {d_reg, l_reg, sp_reg, sz_reg, found_reg, cand_reg[AW-1:0]};
        mem_raddr  = cand_reg[AW-1:0];
        case (state_reg)
            ibrm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    // restart drops the table before this item
                    if (restart)
                    begin
                        count_next = '0;
                    end
                    cand_next  = '0;
                    found_next = 1'b0;
                    full_next  = !restart && (count_reg >= CW'(MAX_ENTRIES));
                    state_next = ibrm_pkg::ST_CAND;
                end
            end
            ibrm_pkg::ST_CAND:
            begin
                // issue the candidate read, or finish when none remain
                if (full_reg || cand_reg >= count_reg)
                begin
                    cand_next  = '0;
                    state_next = ibrm_pkg::ST_DONE;
                end
                else
                begin
                    state_next = ibrm_pkg::ST_CHECK;
                end
            end
            ibrm_pkg::ST_CHECK:
            begin
                if (r_sp != sp_reg || r_sz < sz_reg || r_ovl)
                begin
                    cand_next  = cand_reg + 1'b1;
                    state_next = ibrm_pkg::ST_CAND;
                end
                else
                begin
                    k_next     = '0;
                    state_next = ibrm_pkg::ST_RUSR;
                end
            end
            ibrm_pkg::ST_RUSR:
            begin
                mem_raddr = k_reg[AW-1:0];
                if (k_reg >= count_reg)
                begin
                    // no clashing reuser: take this candidate
                    found_next = 1'b1;
                    state_next = ibrm_pkg::ST_DONE;
                end
                else
                begin
                    state_next = ibrm_pkg::ST_RCHECK;
                end
            end
            ibrm_pkg::ST_RCHECK:
            begin
                if (r_lv && r_li == cand_reg[AW-1:0] && r_ovl)
                begin
                    cand_next  = cand_reg + 1'b1;
                    state_next = ibrm_pkg::ST_CAND;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ibrm_pkg::ST_RUSR;
                end
            end
            ibrm_pkg::ST_DONE:
            begin
                // store the entry unless the table is full, and present the word
                if (!full_reg)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                state_next = ibrm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ibrm_pkg::ST_IDLE;
            end
        endcase
    end

    logic [CW+7:0] cnt_ext, src_ext;
    assign cnt_ext = {8'd0, count_reg};
    assign src_ext = {8'd0, cand_reg};

    // hold busy through the result cycle so no word is taken while the entry is stored
    assign busy         = (state_reg != ibrm_pkg::ST_IDLE);
    assign done         = (state_reg == ibrm_pkg::ST_DONE);
    assign table_full   = full_reg;
    assign entry_index  = full_reg ? 8'd0 : cnt_ext[7:0];
    assign reuse_found  = found_reg;
    assign source_index = found_reg ? src_ext[7:0] : 8'd0;

`include "interval_buffer_reuse_matcher_top_macros.svh"
    `IBRM_ASSERT_IMP(a_full_no_reuse, clk, rst_n, done && table_full, !reuse_found)
    `IBRM_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(MAX_ENTRIES))
    `IBRM_ASSERT_NXT(a_done_one_cycle, clk, rst_n, done, !done)
    `IBRM_ASSERT_IMP(a_found_in_range, clk, rst_n, done && reuse_found,
        cand_reg < count_reg)
endmodule
